// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/sha256_pkg.sv =====
`default_nettype none
package sha256_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_DRAIN,
        ST_UPDATE,
        ST_OUT
    } state_t;

    localparam logic [31:0] PAD_MARKER = 32'h8000_0000;

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        logic [31:0] v;
        case (i)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] v;
        case (i)
            6'd0:  v = 32'h428a2f98; 6'd1:  v = 32'h71374491;
            6'd2:  v = 32'hb5c0fbcf; 6'd3:  v = 32'he9b5dba5;
            6'd4:  v = 32'h3956c25b; 6'd5:  v = 32'h59f111f1;
            6'd6:  v = 32'h923f82a4; 6'd7:  v = 32'hab1c5ed5;
            6'd8:  v = 32'hd807aa98; 6'd9:  v = 32'h12835b01;
            6'd10: v = 32'h243185be; 6'd11: v = 32'h550c7dc3;
            6'd12: v = 32'h72be5d74; 6'd13: v = 32'h80deb1fe;
            6'd14: v = 32'h9bdc06a7; 6'd15: v = 32'hc19bf174;
            6'd16: v = 32'he49b69c1; 6'd17: v = 32'hefbe4786;
            6'd18: v = 32'h0fc19dc6; 6'd19: v = 32'h240ca1cc;
            6'd20: v = 32'h2de92c6f; 6'd21: v = 32'h4a7484aa;
            6'd22: v = 32'h5cb0a9dc; 6'd23: v = 32'h76f988da;
            6'd24: v = 32'h983e5152; 6'd25: v = 32'ha831c66d;
            6'd26: v = 32'hb00327c8; 6'd27: v = 32'hbf597fc7;
            6'd28: v = 32'hc6e00bf3; 6'd29: v = 32'hd5a79147;
            6'd30: v = 32'h06ca6351; 6'd31: v = 32'h14292967;
            6'd32: v = 32'h27b70a85; 6'd33: v = 32'h2e1b2138;
            6'd34: v = 32'h4d2c6dfc; 6'd35: v = 32'h53380d13;
            6'd36: v = 32'h650a7354; 6'd37: v = 32'h766a0abb;
            6'd38: v = 32'h81c2c92e; 6'd39: v = 32'h92722c85;
            6'd40: v = 32'ha2bfe8a1; 6'd41: v = 32'ha81a664b;
            6'd42: v = 32'hc24b8b70; 6'd43: v = 32'hc76c51a3;
            6'd44: v = 32'hd192e819; 6'd45: v = 32'hd6990624;
            6'd46: v = 32'hf40e3585; 6'd47: v = 32'h106aa070;
            6'd48: v = 32'h19a4c116; 6'd49: v = 32'h1e376c08;
            6'd50: v = 32'h2748774c; 6'd51: v = 32'h34b0bcb5;
            6'd52: v = 32'h391c0cb3; 6'd53: v = 32'h4ed8aa4a;
            6'd54: v = 32'h5b9cca4f; 6'd55: v = 32'h682e6ff3;
            6'd56: v = 32'h748f82ee; 6'd57: v = 32'h78a5636f;
            6'd58: v = 32'h84c87814; 6'd59: v = 32'h8cc70208;
            6'd60: v = 32'h90befffa; 6'd61: v = 32'ha4506ceb;
            6'd62: v = 32'hbef9a3f7; default: v = 32'hc67178f2;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] ror(input logic [31:0] x, input int s);
        return (x >> s) | (x << (32 - s));
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

endpackage
`default_nettype wire

// ===== hdl/sha256_if.sv =====
`default_nettype none
interface sha256_msg_if;
    logic        valid;
    logic        ready;
    logic [31:0] message_word;
    logic [2:0]  valid_bytes;
    logic        last_word;

    modport source (output valid, message_word, valid_bytes, last_word, input ready);
    modport sink (input valid, message_word, valid_bytes, last_word, output ready);
endinterface

interface sha256_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_of_digest;

    modport source (output valid, digest_word, word_index, last_of_digest, input ready);
    modport sink (input valid, digest_word, word_index, last_of_digest, output ready);
endinterface
`default_nettype wire

// ===== hdl/sha256_ram.sv =====
`default_nettype none
module sha256_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire                       clk,
    input  wire                       we,
    input  wire [$clog2(DEPTH)-1:0]   waddr,
    input  wire [WIDTH-1:0]           wdata,
    input  wire [$clog2(DEPTH)-1:0]   raddr0,
    input  wire [$clog2(DEPTH)-1:0]   raddr1,
    output logic [WIDTH-1:0]          rdata0,
    output logic [WIDTH-1:0]          rdata1
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata0 <= mem_reg[raddr0];
        rdata1 <= mem_reg[raddr1];
    end
endmodule
`default_nettype wire

// ===== hdl/sha256_hash_engine.sv =====
`default_nettype none
// SHA-256 engine for a stream of big-endian 32-bit message words.
// message: one word per transaction; last_word marks the end of the message and
//   valid_bytes (0..4, values above 4 count as 4) gives its valid leading bytes.
// digest: eight transactions, H0 first, word_index 0..7, last_of_digest on 7.
// Words are taken one per cycle while the block fills. The 16th word of a
// block starts the compression: 64 rounds at one round per cycle through the
// schedule memory, followed by a drain state and a hash update state. On the
// last word the engine writes the padding and length one word per cycle, runs
// one or two more compressions and then presents the digest.
// message.ready is low from the filling of a block until the compression is
// done, and during padding and output. A stalled digest transaction holds its
// word until taken; after the eighth one the engine returns to its initial
// hash and accepts a new message.
// Reset clears the control state and loads the initial hash values at once.
module sha256_hash_engine (
    input wire clk,
    input wire rst_n,
    sha256_msg_if.sink      message,
    sha256_digest_if.source digest
);
    import sha256_pkg::*;

    state_t state_reg, state_next;

    logic [31:0] hash_reg [8];
    logic [31:0] wv_reg [8];
    logic [3:0]  pos_reg;
    logic [5:0]  rc_reg;
    logic [5:0]  cr_reg;
    logic        cv_reg;
    logic [63:0] bits_reg;
    logic        pad_reg;
    logic        marker_reg;
    logic        len_reg;
    logic        final_reg;
    logic [2:0]  idx_reg;

    logic        in_acc, out_acc;
    logic        push_en;
    logic [31:0] push_data;
    logic        compute_en;
    logic [2:0]  nv;
    logic [31:0] keep_mask, pad_bit;
    logic [31:0] x16, x15, x7, x2;
    logic [31:0] wt, t1, t2;
    logic        ram_we;
    logic [3:0]  ram_waddr;
    logic [31:0] ram_wdata;

    assign in_acc  = message.valid && message.ready;
    assign out_acc = digest.valid && digest.ready;
    assign compute_en = cv_reg;
    assign nv = (message.valid_bytes > 3'd4) ? 3'd4 : message.valid_bytes;

    always_comb
    begin
        case (nv)
            3'd0:    begin keep_mask = 32'h0000_0000; pad_bit = 32'h8000_0000; end
            3'd1:    begin keep_mask = 32'hff00_0000; pad_bit = 32'h0080_0000; end
            3'd2:    begin keep_mask = 32'hffff_0000; pad_bit = 32'h0000_8000; end
            3'd3:    begin keep_mask = 32'hffff_ff00; pad_bit = 32'h0000_0080; end
            default: begin keep_mask = 32'hffff_ffff; pad_bit = 32'h0000_0000; end
        endcase
    end

    // Word written into the block this cycle, from the input or the padding.
    always_comb
    begin
        push_en = 1'b0;
        push_data = 32'h0;
        if (state_reg == ST_IDLE && in_acc)
        begin
            push_en = 1'b1;
            if (message.last_word)
            begin
                push_data = (message.message_word & keep_mask) | pad_bit;
            end
            else
            begin
                push_data = message.message_word;
            end
        end
        else if (state_reg == ST_PAD)
        begin
            push_en = 1'b1;
            if (marker_reg)
            begin
                push_data = PAD_MARKER;
            end
            else if (len_reg)
            begin
                push_data = bits_reg[31:0];
            end
            else if (pos_reg == 4'd14)
            begin
                push_data = bits_reg[63:32];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && pos_reg == 4'd15)
                begin
                    state_next = ST_ROUND;
                end
                else if (in_acc && message.last_word)
                begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (pos_reg == 4'd15)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (rc_reg == 6'd63)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (final_reg)
                begin
                    state_next = ST_OUT;
                end
                else if (pad_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (out_acc && idx_reg == 3'd7)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        message.ready = (state_reg == ST_IDLE);
        digest.valid = (state_reg == ST_OUT);
        digest.digest_word = hash_reg[idx_reg];
        digest.word_index = idx_reg;
        digest.last_of_digest = (idx_reg == 3'd7);
        if (compute_en)
        begin
            ram_we = (cr_reg >= 6'd16);
            ram_waddr = cr_reg[3:0];
            ram_wdata = wt;
        end
        else
        begin
            ram_we = push_en;
            ram_waddr = pos_reg;
            ram_wdata = push_data;
        end
    end

    // Two copies of the schedule window give four read ports per round.
    sha256_ram #(.WIDTH(32), .DEPTH(16)) u_ram_a (
        .clk    (clk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .raddr0 (rc_reg[3:0]),
        .raddr1 (rc_reg[3:0] + 4'd1),
        .rdata0 (x16),
        .rdata1 (x15)
    );

    sha256_ram #(.WIDTH(32), .DEPTH(16)) u_ram_b (
        .clk    (clk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .raddr0 (rc_reg[3:0] + 4'd9),
        .raddr1 (rc_reg[3:0] + 4'd14),
        .rdata0 (x7),
        .rdata1 (x2)
    );

    always_comb
    begin
        if (cr_reg < 6'd16)
        begin
            wt = x16;
        end
        else
        begin
            wt = x16 + ssig0(x15) + x7 + ssig1(x2);
        end
        t1 = wv_reg[7] + bsig1(wv_reg[4])
            + ((wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]))
            + round_k(cr_reg) + wt;
        t2 = bsig0(wv_reg[0])
            + ((wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2]) ^ (wv_reg[1] & wv_reg[2]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg <= 4'd0;
            rc_reg <= 6'd0;
            cr_reg <= 6'd0;
            cv_reg <= 1'b0;
            bits_reg <= 64'd0;
            pad_reg <= 1'b0;
            marker_reg <= 1'b0;
            len_reg <= 1'b0;
            final_reg <= 1'b0;
            idx_reg <= 3'd0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= init_hash(3'(i));
            end
        end
        else
        begin
            state_reg <= state_next;
            cv_reg <= (state_reg == ST_ROUND);
            cr_reg <= rc_reg;
            if (state_reg == ST_ROUND)
            begin
                rc_reg <= rc_reg + 6'd1;
            end
            if (push_en)
            begin
                pos_reg <= pos_reg + 4'd1;
            end
            if (state_reg == ST_IDLE && in_acc)
            begin
                if (message.last_word)
                begin
                    bits_reg <= bits_reg + {58'd0, nv, 3'd0};
                    pad_reg <= 1'b1;
                    marker_reg <= (nv == 3'd4);
                end
                else
                begin
                    bits_reg <= bits_reg + 64'd32;
                end
            end
            if (state_reg == ST_PAD)
            begin
                if (marker_reg)
                begin
                    marker_reg <= 1'b0;
                end
                else if (len_reg)
                begin
                    final_reg <= 1'b1;
                end
                else if (pos_reg == 4'd14)
                begin
                    len_reg <= 1'b1;
                end
            end
            if (state_reg == ST_UPDATE)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_reg[i] <= hash_reg[i] + wv_reg[i];
                end
            end
            if (out_acc)
            begin
                idx_reg <= idx_reg + 3'd1;
                if (idx_reg == 3'd7)
                begin
                    // drop back to a fresh message
                    for (int i = 0; i < 8; i++)
                    begin
                        hash_reg[i] <= init_hash(3'(i));
                    end
                    pos_reg <= 4'd0;
                    bits_reg <= 64'd0;
                    pad_reg <= 1'b0;
                    len_reg <= 1'b0;
                    final_reg <= 1'b0;
                end
            end
        end
    end

    // Working variables: load at block start, advance one round per cycle.
    always_ff @(posedge clk)
    begin
        if (push_en && pos_reg == 4'd15)
        begin
            for (int i = 0; i < 8; i++)
            begin
                wv_reg[i] <= hash_reg[i];
            end
        end
        else if (compute_en)
        begin
            wv_reg[0] <= t1 + t2;
            wv_reg[1] <= wv_reg[0];
            wv_reg[2] <= wv_reg[1];
            wv_reg[3] <= wv_reg[2];
            wv_reg[4] <= wv_reg[3] + t1;
            wv_reg[5] <= wv_reg[4];
            wv_reg[6] <= wv_reg[5];
            wv_reg[7] <= wv_reg[6];
        end
    end

`include "assert_macros.svh"
    `ASSERT_NEVER(a_no_overlap, clk, rst_n, message.ready && digest.valid, "input open during output")
    `ASSERT_CLK(a_drain_update, clk, rst_n, state_reg == ST_DRAIN |=> state_reg == ST_UPDATE, "drain not followed by update")
    `ASSERT_CLK(a_digest_end, clk, rst_n, digest.valid && digest.ready && digest.last_of_digest |=> message.ready && pos_reg == 4'd0, "no restart after digest")
    `ASSERT_NEVER(a_wr_rounds, clk, rst_n, compute_en && push_en, "schedule write collision")

endmodule
`default_nettype wire

// ===== verif/sha256_hash_engine_test.sv =====
`timescale 1ns / 100ps
`default_nettype none
module sha256_hash_engine_test;
    import sha256_pkg::*;

    typedef struct packed {
        logic [31:0] message_word;
        logic [2:0]  valid_bytes;
        logic        last_word;
    } msg_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_of_digest;
    } dig_t;

    localparam int STALL_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sha256_msg_if    message ();
    sha256_digest_if digest ();

    sha256_hash_engine dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .message (message.sink),
        .digest  (digest.source)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor state
    logic [31:0] hv [8];
    logic [31:0] win [16];
    logic [3:0]  wpos;
    logic [63:0] nbits;

    msg_t pending_words [$];
    dig_t digest_expected [$];
    int   errors = 0;
    int   send_idle_pct = 29;
    int   recv_idle_pct = 49;
    int   quiet_cycles = 0;
    logic msg_taken = 1'b0;

    function automatic logic [31:0] iv(input int i);
        logic [31:0] t [8];
        t = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
              32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        return t[i];
    endfunction

    function automatic logic [31:0] rk(input int i);
        logic [31:0] t [64];
        t = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
            32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
            32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
            32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
            32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return t[i];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int s);
        return (x >> s) | (x << (32 - s));
    endfunction

    task automatic compress();
        logic [31:0] v [8];
        logic [31:0] t1, t2, x15, x2;
        for (int i = 0; i < 8; i++)
            v[i] = hv[i];
        for (int r = 0; r < 64; r++)
        begin
            if (r >= 16)
            begin
                x15 = win[(r + 1) & 15];
                x2 = win[(r + 14) & 15];
                win[r & 15] = win[r & 15] + (rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3))
                    + win[(r + 9) & 15] + (rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10));
            end
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                + ((v[4] & v[5]) ^ (~v[4] & v[6])) + rk(r) + win[r & 15];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int j = 7; j > 0; j--)
                v[j] = v[j - 1];
            v[0] = t1 + t2;
            v[4] = v[4] + t1;
        end
        for (int i = 0; i < 8; i++)
            hv[i] = hv[i] + v[i];
    endtask

    task automatic load_word(input logic [31:0] w);
        win[wpos] = w;
        wpos = wpos + 4'd1;
        if (wpos == 4'd0)
            compress();
    endtask

    task automatic restart_hash();
        for (int i = 0; i < 8; i++)
            hv[i] = iv(i);
        wpos = '0;
        nbits = '0;
    endtask

    task automatic absorb_word(input msg_t m);
        int n;
        logic [31:0] keep;
        dig_t d;
        if (!m.last_word)
        begin
            nbits = nbits + 64'd32;
            load_word(m.message_word);
            return;
        end
        n = (m.valid_bytes > 3'd4) ? 4 : int'(m.valid_bytes);
        nbits = nbits + 64'(n * 8);
        if (n == 4)
        begin
            load_word(m.message_word);
            load_word(PAD_MARKER);
        end
        else
        begin
            keep = (n == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * n));
            load_word((m.message_word & keep) | (32'h80 << (24 - 8 * n)));
        end
        while (wpos != 4'd14)
            load_word(32'h0);
        load_word(nbits[63:32]);
        load_word(nbits[31:0]);
        for (int i = 0; i < 8; i++)
        begin
            d.digest_word = hv[i];
            d.word_index = 3'(i);
            d.last_of_digest = (i == 7);
            digest_expected.push_back(d);
        end
        restart_hash();
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    // Driver: advance on the falling edge once the current transaction is taken
    always @(negedge clk)
    begin
        msg_t m;
        if (rst_n)
        begin
            if (!message.valid || msg_taken)
            begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    m = pending_words.pop_front();
                    message.valid <= 1'b1;
                    message.message_word <= m.message_word;
                    message.valid_bytes <= m.valid_bytes;
                    message.last_word <= m.last_word;
                end
                else
                    message.valid <= 1'b0;
            end
            digest.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        msg_t m;
        dig_t want;
        logic moved;
        if (rst_n)
        begin
            moved = 1'b0;
            msg_taken <= message.valid && message.ready;
            if (message.valid && message.ready)
            begin
                m.message_word = message.message_word;
                m.valid_bytes = message.valid_bytes;
                m.last_word = message.last_word;
                absorb_word(m);
                moved = 1'b1;
            end
            if (digest.valid && digest.ready)
            begin
                moved = 1'b1;
                if (digest_expected.size() == 0)
                    report_mismatch("unexpected digest word", digest.digest_word, 32'h0);
                else
                begin
                    want = digest_expected.pop_front();
                    if (digest.digest_word !== want.digest_word)
                        report_mismatch("digest_word", digest.digest_word, want.digest_word);
                    if (digest.word_index !== want.word_index)
                        report_mismatch("word_index", 32'(digest.word_index),
                                        32'(want.word_index));
                    if (digest.last_of_digest !== want.last_of_digest)
                        report_mismatch("last_of_digest", 32'(digest.last_of_digest),
                                        32'(want.last_of_digest));
                end
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic queue_word(input logic [31:0] w, input logic [2:0] nb, input logic lw);
        msg_t m;
        m.message_word = w;
        m.valid_bytes = nb;
        m.last_word = lw;
        pending_words.push_back(m);
    endtask

    // Random message: mostly short, a few spanning several blocks
    task automatic queue_message();
        int len;
        len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(16);
        for (int i = 0; i < len; i++)
            queue_word($urandom, ($urandom_range(3) == 0) ? 3'($urandom) : 3'd4, 1'b0);
        queue_word($urandom, 3'($urandom), 1'b1);
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || message.valid || digest_expected.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        message.valid = 1'b0;
        message.message_word = '0;
        message.valid_bytes = '0;
        message.last_word = 1'b0;
        digest.ready = 1'b0;
        for (int i = 0; i < 16; i++)
            win[i] = '0;
        restart_hash();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty message, full-word tail, tails of 2 and 3 bytes, clamped counts, pad boundaries
        queue_word(32'hffffffff, 3'd0, 1'b1);
        queue_word(32'h61626300, 3'd3, 1'b1);
        queue_word(32'hffffffff, 3'd4, 1'b1);
        queue_word(32'h00000000, 3'd7, 1'b1);
        queue_word(32'h12345678, 3'd1, 1'b0);
        queue_word(32'hdeadbeef, 3'd2, 1'b1);
        queue_word(32'h0, 3'd5, 1'b1);
        for (int i = 0; i < 13; i++)
            queue_word(32'ha5a5a5a5 ^ 32'(i), 3'd4, 1'b0);
        queue_word(32'hcafef00d, 3'd4, 1'b1);
        queue_word(32'h55aa55aa, 3'd6, 1'b1);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 49 : 0;
            recv_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 29 : 0;
            while (pending_words.size() < 80)
                queue_message();
            wait_drained();
        end
        repeat (100) @(posedge clk);
        if (errors == 0 && digest_expected.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire
